// ===== sv/depth_tested_point_splat_core_defines.svh =====
// Assertion macros for the point splat core checker.
// Used only by the checker file; no other dependencies.
`ifndef DEPTH_TESTED_POINT_SPLAT_CORE_DEFINES_SVH
`define DEPTH_TESTED_POINT_SPLAT_CORE_DEFINES_SVH

// Implication checked while out of reset.
`define DTPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked in every cycle, reset included.
`define DTPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/dtps_pkg.sv =====
// Shared types and constants for the depth-tested point splat core.
// No dependencies.
package dtps_pkg;

  localparam int COORD_W   = 16;
  localparam int DEPTH_W   = 16;
  localparam int FACE_W    = 3;
  localparam int SCAN_W    = 12;
  localparam int ENTRY_W   = FACE_W + DEPTH_W;
  // Wide enough for any linear pixel index and the cell count itself.
  localparam int IDX_EXT_W = 17;

  typedef enum logic {
    OP_PLOT = 1'b0,
    OP_SCAN = 1'b1
  } op_t;

  // One pixel as held in the store.
  typedef struct packed {
    logic [FACE_W-1:0]         face;
    logic signed [DEPTH_W-1:0] depth;
  } entry_t;

  // Control carried with an item from address stage to update stage.
  typedef struct packed {
    op_t  op;
    logic in_range;
  } item_ctl_t;

endpackage

// ===== sv/depth_tested_point_splat_core.sv =====
// Result path: an accepted item is registered into the update stage, then
// the output register. Throughput: one item per cycle unless out_stall or
// clearing holds input off, set by the store's read-modify-write loop; a
// one-entry write-forwarding register covers back-to-back hits.
// Reset: rst starts a clearing pass over all GRID_ROWS*GRID_COLS entries
// (4096 by default), one entry per cycle, with in_stall high until it ends.
module depth_tested_point_splat_core #(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64,
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                operation,
  input  logic signed [dtps_pkg::COORD_W-1:0] horiz_coord,
  input  logic signed [dtps_pkg::COORD_W-1:0] vert_coord,
  input  logic signed [dtps_pkg::DEPTH_W-1:0] point_depth,
  input  logic [dtps_pkg::FACE_W-1:0]         face_id,
  input  logic [dtps_pkg::SCAN_W-1:0]         scan_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dtps_pkg::FACE_W-1:0]         pixel_face,
  output logic signed [dtps_pkg::DEPTH_W-1:0] pixel_depth,
  output logic                                written,
  output logic                                off_grid
);
  import dtps_pkg::*;

  localparam int CELLS  = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

  // Clearing pass.
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  // Address stage.
  op_t               in_op;
  logic              accept;
  logic [ADDR_W-1:0] idx_addr;
  logic              idx_in_range;

  // Update stage.
  logic                      s1_valid;
  item_ctl_t                 s1_ctl;
  logic [ADDR_W-1:0]         s1_addr;
  logic [FACE_W-1:0]         s1_face;
  logic signed [DEPTH_W-1:0] s1_depth;
  logic                      s1_go;

  // Forwarding of the most recent store write.
  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  entry_t            fwd_data;

  // Store ports and read-modify-write signals.
  logic [ENTRY_W-1:0] ram_rdata;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  entry_t             ram_wdata;
  entry_t             cur;
  logic               replace;
  logic               upd_we;
  entry_t             upd_data;
  logic [FACE_W-1:0]         res_face;
  logic signed [DEPTH_W-1:0] res_depth;
  logic                      res_written;
  logic                      res_off;

  assign in_op    = op_t'(operation);
  assign s1_go    = !out_valid || !out_stall;
  assign in_stall = clearing || (s1_valid && !s1_go);
  assign accept   = in_valid && !in_stall;

  dtps_index #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_index (
    .operation   (in_op),
    .horiz_coord (horiz_coord),
    .vert_coord  (vert_coord),
    .scan_index  (scan_index),
    .addr        (idx_addr),
    .in_range    (idx_in_range)
  );

  dtps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (idx_addr),
    .rdata (ram_rdata)
  );

  // Clearing sweep after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  // Update stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl   <= '{op: in_op, in_range: idx_in_range};
      s1_addr  <= idx_addr;
      s1_face  <= face_id;
      s1_depth <= point_depth;
    end
  end

  // Current pixel: forwarded write wins over the stale read.
  always_comb begin
    if (fwd_valid && (fwd_addr == s1_addr)) begin
      cur = fwd_data;
    end else begin
      cur = entry_t'(ram_rdata);
    end
  end

  // Depth test and result forming.
  always_comb begin
    replace     = (cur.face == '0) || (s1_depth > cur.depth);
    upd_we      = 1'b0;
    upd_data    = '0;
    res_face    = '0;
    res_depth   = '0;
    res_written = 1'b0;
    res_off     = 1'b0;
    case (s1_ctl.op)
      OP_PLOT: begin
        res_off = !s1_ctl.in_range;
        if (s1_ctl.in_range && replace) begin
          upd_we      = 1'b1;
          upd_data    = '{face: s1_face, depth: s1_depth};
          res_written = 1'b1;
        end
      end
      OP_SCAN: begin
        if (s1_ctl.in_range) begin
          upd_we    = 1'b1;
          res_face  = cur.face;
          res_depth = cur.depth;
        end
      end
      default: begin
        upd_we = 1'b0;
      end
    endcase
  end

  // Store write port: clearing sweep or item write-back.
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_valid && s1_go && upd_we;
      ram_waddr = s1_addr;
      ram_wdata = upd_data;
    end
  end

  // Forwarding register follows every item write.
  always_ff @(posedge clk) begin
    if (rst || clearing) begin
      fwd_valid <= 1'b0;
    end else if (ram_we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr <= ram_waddr;
      fwd_data <= ram_wdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_go) begin
      pixel_face  <= res_face;
      pixel_depth <= res_depth;
      written     <= res_written;
      off_grid    <= res_off;
    end
  end

endmodule

// ===== sv/dtps_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module dtps_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the contents before a same-cycle write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/dtps_index.sv =====
// Pixel address generation: floors the point coordinates onto the grid,
// or range-checks a scan index. Depends on dtps_pkg.
module dtps_index #(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64,
  parameter int FRAC_BITS = 8
) (
  input  dtps_pkg::op_t                       operation,
  input  logic signed [dtps_pkg::COORD_W-1:0] horiz_coord,
  input  logic signed [dtps_pkg::COORD_W-1:0] vert_coord,
  input  logic [dtps_pkg::SCAN_W-1:0]         scan_index,
  output logic [$clog2(GRID_ROWS*GRID_COLS)-1:0] addr,
  output logic                                in_range
);
  import dtps_pkg::*;

  localparam int CELLS  = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic signed [17:0] ROW_CTR  = 18'(GRID_ROWS / 2);
  localparam logic signed [17:0] COL_CTR  = 18'(GRID_COLS / 2);
  localparam logic signed [17:0] ROW_LIM  = 18'(GRID_ROWS);
  localparam logic signed [17:0] COL_LIM  = 18'(GRID_COLS);
  localparam logic [IDX_EXT_W-1:0] CELL_LIM = IDX_EXT_W'(CELLS);

  logic signed [COORD_W-1:0] vert_fl;
  logic signed [COORD_W-1:0] horiz_fl;
  logic signed [17:0]        row_s;
  logic signed [17:0]        col_s;
  logic                      plot_ok;
  logic [ADDR_W-1:0]         plot_addr;
  logic [IDX_EXT_W-1:0]      scan_ext;

  // Arithmetic shift is floor division by the fixed-point scale.
  always_comb begin
    vert_fl   = vert_coord >>> FRAC_BITS;
    horiz_fl  = horiz_coord >>> FRAC_BITS;
    row_s     = 18'(vert_fl) + ROW_CTR;
    col_s     = 18'(horiz_fl) + COL_CTR;
    plot_ok   = (row_s >= 18'sd0) && (row_s < ROW_LIM) &&
                (col_s >= 18'sd0) && (col_s < COL_LIM);
    plot_addr = row_s[ADDR_W-1:0] * ADDR_W'(GRID_COLS) + col_s[ADDR_W-1:0];
    scan_ext  = IDX_EXT_W'(scan_index);
  end

  // Select by operation.
  always_comb begin
    case (operation)
      OP_PLOT: begin
        addr     = plot_addr;
        in_range = plot_ok;
      end
      OP_SCAN: begin
        addr     = scan_ext[ADDR_W-1:0];
        in_range = scan_ext < CELL_LIM;
      end
      default: begin
        addr     = '0;
        in_range = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/dtps_checker.sv =====
// Port-level checks for the point splat core, bound to the top level.
// Depends on depth_tested_point_splat_core_defines.svh and dtps_pkg.
`include "depth_tested_point_splat_core_defines.svh"

module dtps_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [dtps_pkg::FACE_W-1:0]         pixel_face,
  input logic signed [dtps_pkg::DEPTH_W-1:0] pixel_depth,
  input logic                                written,
  input logic                                off_grid
);
  import dtps_pkg::*;

  // A stalled result beat stays offered.
  `DTPS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped under stall")

  // A dropped point never reports a write.
  `DTPS_ASSERT(a_off_no_write, out_valid && off_grid |-> !written, "off-grid point marked written")

  // Written or off-grid plot results carry no pixel contents.
  `DTPS_ASSERT(a_plot_zero, out_valid && (written || off_grid) |-> (pixel_face == '0) && (pixel_depth == '0), "plot result carries pixel data")

  // The clearing pass holds off input right after reset.
  `DTPS_ASSERT_ALWAYS(a_clear_stall, rst |=> in_stall, "input taken during clearing pass")

endmodule

bind depth_tested_point_splat_core dtps_checker u_dtps_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pixel_face  (pixel_face),
  .pixel_depth (pixel_depth),
  .written     (written),
  .off_grid    (off_grid)
);

// ===== verif/tb_depth_tested_point_splat_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for depth_tested_point_splat_core: plots and scans driven
// over valid/stall, results compared with an in-bench z-buffer predictor.
// Depends on dtps_pkg and the core RTL only.
module tb_depth_tested_point_splat_core;
  import dtps_pkg::*;

  localparam int ROWS       = 64;
  localparam int COLS       = 64;
  localparam int FRAC       = 8;
  localparam int CELLS      = ROWS * COLS;
  localparam int QUIET_MAX  = 12000;
  localparam int HOLD_SPAN  = 400;

  typedef struct packed {
    logic [FACE_W-1:0]         face;
    logic signed [DEPTH_W-1:0] depth;
    logic                      written;
    logic                      off_grid;
  } splat_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      operation = 1'b0;
  logic signed [COORD_W-1:0] horiz_coord = '0;
  logic signed [COORD_W-1:0] vert_coord = '0;
  logic signed [DEPTH_W-1:0] point_depth = '0;
  logic [FACE_W-1:0]         face_id = '0;
  logic [SCAN_W-1:0]         scan_index = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [FACE_W-1:0]         pixel_face;
  logic signed [DEPTH_W-1:0] pixel_depth;
  logic                      written;
  logic                      off_grid;

  // Predicted z-buffer contents and pending results
  logic [FACE_W-1:0]         zbuf_face [CELLS];
  logic signed [DEPTH_W-1:0] zbuf_depth [CELLS];
  splat_result_t             pending_pixels [$];

  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  tx_gaps_on = 1'b1;
  bit  rx_gaps_on = 1'b1;
  int  hold_asks = 0;
  int  holds_served = 0;
  int  hold_left = 0;
  int  rx_stall_left = 0;

  depth_tested_point_splat_core #(
    .GRID_ROWS(ROWS),
    .GRID_COLS(COLS),
    .FRAC_BITS(FRAC)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .horiz_coord(horiz_coord),
    .vert_coord(vert_coord),
    .point_depth(point_depth),
    .face_id(face_id),
    .scan_index(scan_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_face(pixel_face),
    .pixel_depth(pixel_depth),
    .written(written),
    .off_grid(off_grid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // Z-buffer update for one item; floor of Q8.8 is an arithmetic shift
  function automatic splat_result_t predict_splat(op_t op, logic signed [COORD_W-1:0] h,
                                                  logic signed [COORD_W-1:0] v,
                                                  logic signed [DEPTH_W-1:0] d,
                                                  logic [FACE_W-1:0] f,
                                                  logic [SCAN_W-1:0] idx);
    splat_result_t r;
    int row;
    int col;
    int pix;
    r = '0;
    if (op == OP_PLOT) begin
      row = ROWS / 2 + (int'(v) >>> FRAC);
      col = COLS / 2 + (int'(h) >>> FRAC);
      if (row < 0 || row >= ROWS || col < 0 || col >= COLS) begin
        r.off_grid = 1'b1;
      end else begin
        pix = row * COLS + col;
        // face zero still counts as empty
        if (zbuf_face[pix] == '0 || d > zbuf_depth[pix]) begin
          zbuf_face[pix]  = f;
          zbuf_depth[pix] = d;
          r.written       = 1'b1;
        end
      end
    end else if (int'(idx) < CELLS) begin
      pix             = int'(idx);
      r.face          = zbuf_face[pix];
      r.depth         = zbuf_depth[pix];
      zbuf_face[pix]  = '0;
      zbuf_depth[pix] = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, int want, int got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
    mismatches++;
  endtask

  // Offer one beat until taken, then optionally drop valid for a gap
  task automatic send_item(op_t op, logic signed [COORD_W-1:0] h,
                           logic signed [COORD_W-1:0] v,
                           logic signed [DEPTH_W-1:0] d,
                           logic [FACE_W-1:0] f, logic [SCAN_W-1:0] idx);
    int gap;
    @(negedge clk);
    in_valid    <= 1'b1;
    operation   <= op;
    horiz_coord <= h;
    vert_coord  <= v;
    point_depth <= d;
    face_id     <= f;
    scan_index  <= idx;
    do @(posedge clk); while (in_stall);
    pending_pixels.push_back(predict_splat(op, h, v, d, f, idx));
    gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Q8.8 coordinate landing in the given grid cell, random fraction
  function automatic logic signed [COORD_W-1:0] coord_in_cell(int cell_pos, int half);
    return COORD_W'((cell_pos - half) * (1 << FRAC) + int'($urandom_range(0, (1 << FRAC) - 1)));
  endfunction

  function automatic logic [FACE_W-1:0] pick_face();
    if ($urandom_range(0, 9) == 0) return FACE_W'($urandom_range(0, 7));
    return FACE_W'($urandom_range(1, 6));
  endfunction

  // Grid edges, depth ordering, off-grid drops, odd faces, scans
  task automatic test_directed();
    send_item(OP_PLOT, 16'sh0000, 16'sh0000, 16'sh0100, 3'd1, 12'd0);
    send_item(OP_PLOT, 16'sh0080, 16'sh00FF, 16'sh0080, 3'd2, 12'hFFF);
    send_item(OP_PLOT, 16'sh00FF, 16'sh0001, 16'sh0100, 3'd3, 12'd0);
    send_item(OP_PLOT, 16'sh0000, 16'sh0000, 16'sh7FFF, 3'd6, 12'd0);
    send_item(OP_PLOT, -16'sd1, -16'sd1, -16'sd32768, 3'd4, 12'd0);
    send_item(OP_PLOT, -16'sd8192, -16'sd8192, 16'sh1234, 3'd5, 12'd0);
    send_item(OP_PLOT, 16'sd8191, 16'sd8191, 16'sh0042, 3'd1, 12'd0);
    send_item(OP_PLOT, -16'sd8193, 16'sh0000, 16'sh0001, 3'd2, 12'd0);
    send_item(OP_PLOT, 16'sd8192, 16'sh0000, 16'sh0001, 3'd2, 12'd0);
    send_item(OP_PLOT, 16'sh0000, -16'sd8193, 16'sh0001, 3'd3, 12'd0);
    send_item(OP_PLOT, 16'sh0000, 16'sd8192, 16'sh0001, 3'd3, 12'd0);
    send_item(OP_PLOT, -16'sd32768, 16'sd32767, 16'sh7FFF, 3'd6, 12'd0);
    send_item(OP_PLOT, 16'sd32767, -16'sd32768, -16'sd32768, 3'd6, 12'd0);
    // face zero leaves the pixel empty, face seven occupies it
    send_item(OP_PLOT, 16'sh0100, 16'sh0000, 16'sh4000, 3'd0, 12'd0);
    send_item(OP_PLOT, 16'sh01FF, 16'sh0000, -16'sd5, 3'd3, 12'd0);
    send_item(OP_PLOT, 16'sh0200, 16'sh0000, 16'sh0000, 3'd7, 12'd0);
    send_item(OP_PLOT, 16'sh0200, 16'sh0000, -16'sd1, 3'd1, 12'd0);
    send_item(OP_PLOT, 16'sh0300, 16'sh0000, 16'sh2222, 3'd0, 12'd0);
    send_item(OP_SCAN, 16'sh0000, 16'sh0000, 16'sh0000, 3'd0, 12'd2080);
    send_item(OP_SCAN, 16'sh7FFF, -16'sd1, 16'sh0000, 3'd7, 12'd2080);
    send_item(OP_SCAN, 16'sh0000, 16'sh0000, 16'sh0000, 3'd0, 12'd2083);
    send_item(OP_SCAN, 16'sh0000, 16'sh0000, 16'sh0000, 3'd0, 12'd0);
    send_item(OP_SCAN, 16'sh0000, 16'sh0000, 16'sh0000, 3'd0, 12'd4095);
    send_item(OP_SCAN, 16'sh0000, 16'sh0000, 16'sh0000, 3'd0, 12'd2081);
    send_item(OP_SCAN, 16'sh0000, 16'sh0000, 16'sh0000, 3'd0, 12'd2082);
  endtask

  // Mix of plots around a hot patch, wide plots, off-grid noise and scans
  task automatic test_random_mix(int count);
    int kind;
    logic signed [COORD_W-1:0] h;
    logic signed [COORD_W-1:0] v;
    logic [SCAN_W-1:0] idx;
    for (int i = 0; i < count; i++) begin
      tx_gaps_on = (i % 300) < 240;
      rx_gaps_on = ((i + 150) % 300) < 240;
      kind = $urandom_range(0, 99);
      h    = COORD_W'($urandom);
      v    = COORD_W'($urandom);
      idx  = SCAN_W'($urandom);
      if (kind < 70) begin
        if ($urandom_range(0, 1) == 1) begin
          h = coord_in_cell($urandom_range(28, 35), COLS / 2);
          v = coord_in_cell($urandom_range(28, 35), ROWS / 2);
        end else begin
          h = COORD_W'(int'($urandom_range(0, COLS * 256 - 1)) - COLS * 128);
          v = COORD_W'(int'($urandom_range(0, ROWS * 256 - 1)) - ROWS * 128);
        end
      end
      if (kind >= 80 && $urandom_range(0, 1) == 1)
        idx = SCAN_W'($urandom_range(28, 35) * COLS + $urandom_range(28, 35));
      send_item((kind < 80) ? OP_PLOT : OP_SCAN, h, v, DEPTH_W'($urandom), pick_face(), idx);
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_back_pressure(int count);
    tx_gaps_on = 1'b0;
    hold_asks++;
    for (int i = 0; i < count; i++)
      send_item(op_t'($urandom_range(0, 3) == 0),
                coord_in_cell($urandom_range(30, 33), COLS / 2),
                coord_in_cell($urandom_range(30, 33), ROWS / 2),
                DEPTH_W'($urandom), pick_face(),
                SCAN_W'($urandom_range(30, 33) * COLS + $urandom_range(30, 33)));
    tx_gaps_on = 1'b1;
  endtask

  // Back-to-back hits on one pixel to exercise write forwarding
  task automatic test_same_pixel_bursts(int bursts);
    int row;
    int col;
    logic signed [COORD_W-1:0] h;
    logic signed [COORD_W-1:0] v;
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    for (int b = 0; b < bursts; b++) begin
      row = $urandom_range(0, ROWS - 1);
      col = $urandom_range(0, COLS - 1);
      for (int k = 0; k < 10; k++) begin
        h = coord_in_cell(col, COLS / 2);
        v = coord_in_cell(row, ROWS / 2);
        send_item(op_t'($urandom_range(0, 4) == 0), h, v,
                  DEPTH_W'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 15)),
                  pick_face(), SCAN_W'(row * COLS + col));
      end
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Receiver stall pattern; a long hold-off is counted here when asked for
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_asks != holds_served) begin
      holds_served++;
      hold_left = HOLD_SPAN - 1;
      out_stall <= 1'b1;
    end else if (rx_stall_left > 0) begin
      out_stall <= 1'b1;
      rx_stall_left--;
    end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
      rx_stall_left = gap_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk) begin
    splat_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result beat", 0, 1);
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_face !== want.face)
          report_mismatch("pixel_face", int'(want.face), int'(pixel_face));
        if (pixel_depth !== want.depth)
          report_mismatch("pixel_depth", int'(want.depth), int'(pixel_depth));
        if (written !== want.written)
          report_mismatch("written", int'(want.written), int'(written));
        if (off_grid !== want.off_grid)
          report_mismatch("off_grid", int'(want.off_grid), int'(off_grid));
      end
    end
  end

  // Watchdog: too long without any beat on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      zbuf_face[i]  = '0;
      zbuf_depth[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mix(1300);
    test_back_pressure(100);
    test_same_pixel_bursts(30);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
